FILE: hw/rtl/lcdmst_pkg.sv
// ----------------------------------------------------------------------------
// lcdmst_pkg
// shared types, timing constants and helpers for the lcd mode timing core
// ----------------------------------------------------------------------------
package lcdmst_pkg;

    localparam int unsigned DOT_W  = 9;
    localparam int unsigned LINE_W = 8;
    localparam int unsigned SRC_W  = 4;
    localparam int unsigned CFG_W  = 8;
    localparam int unsigned IDX_W  = 2;

    localparam logic [DOT_W-1:0]  DOTS_PER_LINE = 9'd456;
    localparam logic [DOT_W-1:0]  SEARCH_DOTS   = 9'd80;
    localparam logic [DOT_W-1:0]  DOT_MAX       = 9'd511;
    localparam logic [LINE_W-1:0] LAST_LINE     = 8'd153;
    localparam logic [LINE_W-1:0] VISIBLE_LINES = 8'd144;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_XFER   = 2'd3
    } mode_t;

    typedef enum logic [IDX_W-1:0] {
        REG_DISPLAY_ENABLE = 2'd0,
        REG_STAT_ENABLE    = 2'd1,
        REG_COMPARE_LINE   = 2'd2
    } reg_index_t;

    localparam logic [1:0] SRC_HBLANK = 2'd0;
    localparam logic [1:0] SRC_VBLANK = 2'd1;
    localparam logic [1:0] SRC_OAM    = 2'd2;
    localparam logic [1:0] SRC_LYC    = 2'd3;

    // returns {request, updated source lines}
    function automatic logic [SRC_W:0] drive_source(
        input logic [SRC_W-1:0] lines,
        input logic [SRC_W-1:0] enables,
        input logic [1:0]       idx,
        input logic             on
    );
        logic [SRC_W-1:0] upd;
        logic             req;
        upd = lines;
        req = 1'b0;
        if (on && enables[idx]) begin
            req      = (lines == '0);
            upd[idx] = 1'b1;
        end else begin
            upd[idx] = 1'b0;
        end
        return {req, upd};
    endfunction

    // mode code doubles as its stat source index, pixel transfer has none
    function automatic logic [1:0] mode_source(input mode_t mode);
        return 2'(mode);
    endfunction

endpackage

FILE: hw/rtl/lcd_mode_timing_stat_irq_core.sv
// ----------------------------------------------------------------------------
// lcd_mode_timing_stat_irq_core
// lcd controller dot timing: modes, line counter, line compare, stat/vblank irq
// ----------------------------------------------------------------------------
// Each item is one dot tick and yields one result item. The timing state
// (only while the display is enabled) and the result register are updated in
// the same cycle the tick is accepted, so a new tick is taken every cycle as
// long as the result register is free or being drained; throughput is one item
// per clock. Register writes are taken at any time and go through the
// configuration channel, which is always ready.
module lcd_mode_timing_stat_irq_core
    import lcdmst_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,

    input  logic              in_valid,
    output logic              in_ready,
    input  logic              transfer_done,

    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        visible_mode,
    output logic [LINE_W-1:0] line_number,
    output logic              coincidence,
    output logic              stat_irq,
    output logic              vblank_irq
);

    logic              display_enable_reg;
    logic [SRC_W-1:0]  stat_enable_reg;
    logic [LINE_W-1:0] compare_line_reg;

    logic [DOT_W-1:0]  dot_count_reg, dot_count_next;
    mode_t             mode_reg, mode_next;
    mode_t             shown_reg, shown_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic [SRC_W-1:0]  irq_src_reg, irq_src_next;
    logic              match_reg, match_next;

    logic              out_valid_reg;
    mode_t             out_mode_reg;
    logic [LINE_W-1:0] out_line_reg;
    logic              out_match_reg;
    logic              out_stat_reg;
    logic              out_vblank_reg;

    logic              accept;
    logic [DOT_W-1:0]  dot_inc;
    logic [LINE_W:0]   line_inc;
    logic              lyc_check;
    logic              stat_pulse;
    logic              vblank_pulse;
    logic [SRC_W:0]    drv;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_enable_reg <= 1'b0;
            stat_enable_reg    <= '0;
            compare_line_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (reg_index_t'(cfg_index))
                REG_DISPLAY_ENABLE: display_enable_reg <= cfg_data[0];
                REG_STAT_ENABLE:    stat_enable_reg    <= cfg_data[SRC_W-1:0];
                REG_COMPARE_LINE:   compare_line_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // dot, mode and line sequencing
    always_comb
    begin
        dot_inc        = (dot_count_reg < DOT_MAX) ? dot_count_reg + 9'd1 : dot_count_reg;
        line_inc       = {1'b0, line_reg} + 9'd1;
        dot_count_next = dot_inc;
        mode_next      = mode_reg;
        line_next      = line_reg;
        match_next     = match_reg;
        lyc_check      = 1'b0;
        case (mode_reg)
            MODE_OAM:
            begin
                if (dot_inc >= SEARCH_DOTS)
                    mode_next = MODE_XFER;
            end
            MODE_XFER:
            begin
                if (transfer_done)
                    mode_next = MODE_HBLANK;
            end
            MODE_HBLANK:
            begin
                if (dot_inc >= DOTS_PER_LINE)
                begin
                    line_next      = line_inc[LINE_W-1:0];
                    mode_next      = (line_inc[LINE_W-1:0] >= VISIBLE_LINES) ?
                                     MODE_VBLANK : MODE_OAM;
                    lyc_check      = 1'b1;
                    dot_count_next = '0;
                end
            end
            MODE_VBLANK:
            begin
                if (dot_inc >= DOTS_PER_LINE)
                begin
                    dot_count_next = '0;
                    if (line_inc > {1'b0, LAST_LINE})
                    begin
                        // frame wrap, no compare here
                        mode_next = MODE_OAM;
                        line_next = '0;
                    end
                    else
                    begin
                        line_next = line_inc[LINE_W-1:0];
                        lyc_check = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        if (lyc_check)
            match_next = (line_next == compare_line_reg);
    end

    // visible mode, stat sources and irq requests
    always_comb
    begin
        shown_next   = shown_reg;
        irq_src_next = irq_src_reg;
        stat_pulse   = 1'b0;
        vblank_pulse = 1'b0;
        drv          = '0;
        if (shown_reg != mode_reg)
        begin
            shown_next = mode_reg;
            if (shown_reg == MODE_VBLANK)
            begin
                drv          = drive_source(irq_src_next, stat_enable_reg, SRC_OAM, 1'b0);
                irq_src_next = drv[SRC_W-1:0];
            end
            if (shown_reg != MODE_XFER)
            begin
                drv          = drive_source(irq_src_next, stat_enable_reg,
                                            mode_source(shown_reg), 1'b0);
                irq_src_next = drv[SRC_W-1:0];
            end
            if (mode_reg != MODE_XFER)
            begin
                drv          = drive_source(irq_src_next, stat_enable_reg,
                                            mode_source(mode_reg), 1'b1);
                irq_src_next = drv[SRC_W-1:0];
                stat_pulse   = stat_pulse | drv[SRC_W];
            end
            if (mode_reg == MODE_VBLANK)
            begin
                drv          = drive_source(irq_src_next, stat_enable_reg, SRC_OAM, 1'b1);
                irq_src_next = drv[SRC_W-1:0];
                stat_pulse   = stat_pulse | drv[SRC_W];
                vblank_pulse = 1'b1;
            end
        end
        if (lyc_check)
        begin
            drv          = drive_source(irq_src_next, stat_enable_reg, SRC_LYC, match_next);
            irq_src_next = drv[SRC_W-1:0];
            stat_pulse   = stat_pulse | drv[SRC_W];
        end
    end

    // timing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_count_reg <= '0;
            mode_reg      <= MODE_HBLANK;
            shown_reg     <= MODE_HBLANK;
            line_reg      <= '0;
            irq_src_reg   <= '0;
            match_reg     <= 1'b0;
        end
        else if (accept && display_enable_reg)
        begin
            dot_count_reg <= dot_count_next;
            mode_reg      <= mode_next;
            shown_reg     <= shown_next;
            line_reg      <= line_next;
            irq_src_reg   <= irq_src_next;
            match_reg     <= match_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_mode_reg   <= display_enable_reg ? shown_next : shown_reg;
            out_line_reg   <= display_enable_reg ? line_next  : line_reg;
            out_match_reg  <= display_enable_reg ? match_next : match_reg;
            out_stat_reg   <= display_enable_reg && stat_pulse;
            out_vblank_reg <= display_enable_reg && vblank_pulse;
        end
    end

    assign out_valid    = out_valid_reg;
    assign visible_mode = 2'(out_mode_reg);
    assign line_number  = out_line_reg;
    assign coincidence  = out_match_reg;
    assign stat_irq     = out_stat_reg;
    assign vblank_irq   = out_vblank_reg;

    // vblank mode exactly on the lines past the visible area
    a_vblank_lines: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_VBLANK) == (line_reg >= VISIBLE_LINES))
        else $error("internal mode disagrees with line counter");

    a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg <= LAST_LINE)
        else $error("line counter beyond last line");

    a_vblank_irq_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_vblank_reg |-> out_mode_reg == MODE_VBLANK)
        else $error("vblank request without vblank mode");

    a_stat_irq_src: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stat_reg |-> irq_src_reg != '0)
        else $error("stat request with stat line low");

    a_disabled_hold: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !display_enable_reg |=> $stable(dot_count_reg) && $stable(line_reg))
        else $error("timing advanced while display disabled");

endmodule
